// ===== rtl/ffpa_pkg.sv =====
// Package for the flash file place-and-append core.
// Holds the file table sizes, segment geometry, result kinds and sequencer states.
// Used by rtl/flash_file_place_and_append_core.sv; depends on nothing else.
package ffpa_pkg;

  localparam int FILE_COUNT    = 10;
  localparam int SEGMENT_BYTES = 512;
  localparam int SEG_BITS      = $clog2(SEGMENT_BYTES);
  localparam int IDX_W         = (FILE_COUNT > 1) ? $clog2(FILE_COUNT) : 1;

  localparam logic [15:0] REGION_BASE_RESET = 16'hF000;
  localparam logic [7:0]  BYTE_LF           = 8'h0A;
  localparam logic [7:0]  BYTE_CR           = 8'h0D;

  typedef enum logic [2:0] {
    KIND_PLACED  = 3'd0,
    KIND_ERASE   = 3'd1,
    KIND_PROGRAM = 3'd2,
    KIND_LOCK    = 3'd3,
    KIND_REJECT  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REJECT,
    S_SUM,
    S_BASE,
    S_CROSS,
    S_APPEND,
    S_PROG,
    S_LOCK
  } state_t;

  // Start address of the segment that holds a flash address.
  function automatic logic [15:0] seg_of(input logic [15:0] a);
    logic [15:0] r;
    r = a;
    r[SEG_BITS-1:0] = '0;
    return r;
  endfunction

endpackage

// ===== rtl/flash_file_place_and_append_core.sv =====
// Top level of the flash file place-and-append core: file tables, a small
// sequencer around one shared 16-bit adder, and a registered result beat.
// Depends on rtl/ffpa_pkg.sv.

// The core keeps a table of FILE_COUNT files packed one after another from
// region_base. A place beat must finish before the next beat can be taken:
// the lengths of the lower-numbered files are summed one per cycle through
// the shared adder, then the base is added and the segment crossing is
// checked. An append beat steps through accept, first-append load with
// optional erase, program and optional lock, one result beat at most per
// cycle, and a rejected index steps through accept and a reject beat.
// Results come out of a registered output stage; the sequencer holds while
// it is full and out_ready is low.
module flash_file_place_and_append_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [3:0]           file_index,
  input  logic [12:0]          file_length,
  input  logic [7:0]           data_byte,
  input  logic                 chunk_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ffpa_pkg::kind_t      kind,
  output logic [15:0]          address,
  output logic [7:0]           data,
  output logic                 last
);
  import ffpa_pkg::*;

  state_t state, state_next;

  logic [15:0] region_base;
  logic [12:0] length_table [FILE_COUNT];
  logic [15:0] start_table  [FILE_COUNT];
  logic [15:0] write_pointer [FILE_COUNT];
  logic [FILE_COUNT-1:0] started_flags;
  logic [15:0] last_erased_segment;

  // Latched item.
  logic             act;
  logic [IDX_W-1:0] fi;
  logic [12:0]      flen;
  logic [7:0]       dbyte;
  logic             cend;

  logic [15:0]      acc;
  logic [IDX_W-1:0] cnt;

  // Shared adder.
  logic [15:0] add_a, add_b, add_sum;

  logic        out_free;
  logic        push;
  kind_t       push_kind;
  logic [15:0] push_addr;
  logic [7:0]  push_data;
  logic        push_last;

  logic        bad_index;
  logic        dropped;
  logic [13:0] cross_sum;
  logic        crosses;
  logic [15:0] start_seg;
  logic        need_erase;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign add_sum   = add_a + add_b;
  assign bad_index = 32'(file_index) >= FILE_COUNT;
  assign dropped   = (dbyte == BYTE_LF) || (dbyte == BYTE_CR);
  assign cross_sum = 14'(acc[SEG_BITS-1:0]) + 14'(flen);
  assign crosses   = cross_sum > 14'(SEGMENT_BYTES);
  assign start_seg = seg_of(start_table[fi]);
  assign need_erase = (fi == '0) || (start_seg != last_erased_segment);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    add_a      = acc;
    add_b      = 16'd0;
    push       = 1'b0;
    push_kind  = KIND_PLACED;
    push_addr  = 16'd0;
    push_data  = 8'd0;
    push_last  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (bad_index) begin
            state_next = S_REJECT;
          end else if (action) begin
            state_next = S_APPEND;
          end else begin
            state_next = S_SUM;
          end
        end
      end
      S_REJECT: begin
        if (out_free) begin
          push       = 1'b1;
          push_kind  = KIND_REJECT;
          push_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SUM: begin
        add_a = acc;
        add_b = 16'(length_table[cnt]);
        if (cnt == fi) begin
          state_next = S_BASE;
        end
      end
      S_BASE: begin
        add_a      = region_base;
        add_b      = acc;
        state_next = S_CROSS;
      end
      S_CROSS: begin
        add_a = seg_of(acc);
        add_b = 16'(SEGMENT_BYTES);
        if (out_free) begin
          push       = 1'b1;
          push_kind  = KIND_PLACED;
          push_addr  = crosses ? add_sum : acc;
          push_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_APPEND: begin
        if (started_flags[fi]) begin
          state_next = S_PROG;
        end else if (out_free) begin
          if (need_erase) begin
            push      = 1'b1;
            push_kind = KIND_ERASE;
            push_addr = start_seg;
            push_last = dropped && !cend;
          end
          state_next = S_PROG;
        end
      end
      S_PROG: begin
        add_a = write_pointer[fi];
        add_b = 16'd1;
        if (dropped) begin
          state_next = cend ? S_LOCK : S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_kind  = KIND_PROGRAM;
          push_addr  = write_pointer[fi];
          push_data  = dbyte;
          push_last  = !cend;
          state_next = cend ? S_LOCK : S_IDLE;
        end
      end
      S_LOCK: begin
        if (out_free) begin
          push       = 1'b1;
          push_kind  = KIND_LOCK;
          push_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state and tables whose reset value is defined.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base         <= REGION_BASE_RESET;
      started_flags       <= '0;
      last_erased_segment <= 16'd0;
      out_valid           <= 1'b0;
      for (int i = 0; i < FILE_COUNT; i++) begin
        length_table[i] <= 13'd0;
        start_table[i]  <= 16'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        region_base <= cfg_data;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && in_valid && !bad_index && !action) begin
        length_table[file_index[IDX_W-1:0]] <= file_length;
      end
      if (state == S_CROSS && out_free) begin
        start_table[fi] <= push_addr;
      end
      if (state == S_APPEND && !started_flags[fi] && out_free) begin
        started_flags[fi] <= 1'b1;
        if (need_erase) begin
          last_erased_segment <= start_seg;
        end
      end
    end
  end

  // Payload registers: latched item, accumulator, pointers, result beat.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      act   <= action;
      fi    <= file_index[IDX_W-1:0];
      flen  <= file_length;
      dbyte <= data_byte;
      cend  <= chunk_end;
      acc   <= 16'd0;
      cnt   <= '0;
    end
    if (state == S_SUM && cnt != fi) begin
      acc <= add_sum;
      cnt <= cnt + 1'b1;
    end
    if (state == S_BASE) begin
      acc <= add_sum;
    end
    if (state == S_APPEND && !started_flags[fi] && out_free) begin
      write_pointer[fi] <= start_table[fi];
    end
    if (state == S_PROG && !dropped && out_free) begin
      write_pointer[fi] <= add_sum;
    end
    if (push) begin
      kind    <= push_kind;
      address <= push_addr;
      data    <= push_data;
      last    <= push_last;
    end
  end

  // The latched action must agree with the path the sequencer took.
  a_path_matches_action: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM || state == S_BASE || state == S_CROSS) |-> !act)
    else $error("place path taken for an append beat");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again while an item is in work");

  a_erase_aligned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_ERASE) |-> (address[SEG_BITS-1:0] == '0))
    else $error("erase address not on a segment boundary");

  a_terminal_kinds_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_LOCK || kind == KIND_REJECT || kind == KIND_PLACED))
      |-> last)
    else $error("placed, lock or reject beat without last");

  a_push_only_when_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result beat overwrote a pending beat");

endmodule

// ===== verif/flash_file_place_and_append_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for flash_file_place_and_append_core: a queue-fed driver,
// a monitor with its own prediction of the file table, and random stalls on both sides.
// Depends on rtl/ffpa_pkg.sv and rtl/flash_file_place_and_append_core.sv.
module flash_file_place_and_append_core_test;
  import ffpa_pkg::*;

  localparam logic ACT_PLACE   = 1'b0;
  localparam logic ACT_APPEND  = 1'b1;
  localparam int   WRAP_FILE   = 8;
  localparam int   DRAIN_CYCLES = 24;
  localparam int   STUCK_LIMIT = 3000;
  localparam int   LONG_HOLD   = 300;
  localparam int   RANDOM_PER_PHASE = 109;

  typedef struct packed {
    logic        action;
    logic [3:0]  file_index;
    logic [12:0] file_length;
    logic [7:0]  data_byte;
    logic        chunk_end;
  } file_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic        last;
  } flash_op_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [3:0]  file_index = 4'd0;
  logic [12:0] file_length = 13'd0;
  logic [7:0]  data_byte = 8'h00;
  logic        chunk_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  kind_t       kind;
  logic [15:0] address;
  logic [7:0]  data;
  logic        last;

  flash_file_place_and_append_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .file_index (file_index),
    .file_length(file_length),
    .data_byte  (data_byte),
    .chunk_end  (chunk_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .address    (address),
    .data       (data),
    .last       (last)
  );

  // Shadow copy of the file table and configuration.
  logic [15:0] region_base = REGION_BASE_RESET;
  logic [12:0] length_tbl [FILE_COUNT] = '{default: '0};
  logic [15:0] start_tbl [FILE_COUNT] = '{default: '0};
  logic [15:0] wptr_tbl [FILE_COUNT] = '{default: '0};
  bit          started [FILE_COUNT] = '{default: 1'b0};
  logic [15:0] last_erased = 16'h0000;

  file_beat_t pending_beats[$];
  flash_op_t  expected_ops[$];
  bit         in_taken = 1'b0;
  int         beats_in = 0;
  int         beats_sent = 0;
  int         gap_left = 0;
  int         hold_left = 0;
  int         ready_cycle = 0;
  bit         long_hold_done = 1'b0;
  int         errors = 0;
  int         stuck_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] seg_base(input logic [15:0] a);
    return a - (a % 16'(SEGMENT_BYTES));
  endfunction

  function automatic flash_op_t make_op(input kind_t k, input logic [15:0] a,
                                        input logic [7:0] d);
    flash_op_t op;
    op.kind = k;
    op.address = a;
    op.data = d;
    op.last = 1'b0;
    return op;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic predict_flash_ops(input file_beat_t b);
    flash_op_t   ops[$];
    logic [15:0] sum;
    logic [15:0] addr;
    logic [15:0] seg;
    logic [15:0] offset;
    int          fi;
    fi = b.file_index;
    if (fi >= FILE_COUNT) begin
      ops.push_back(make_op(KIND_REJECT, 16'h0000, 8'h00));
    end else if (b.action == ACT_PLACE) begin
      length_tbl[fi] = b.file_length;
      sum = 16'h0000;
      for (int i = 0; i < fi; i++) sum = sum + 16'(length_tbl[i]);
      addr = region_base + sum;
      seg = seg_base(addr);
      offset = addr - seg;
      if (int'(offset) + int'(b.file_length) > SEGMENT_BYTES)
        addr = seg + 16'(SEGMENT_BYTES);
      start_tbl[fi] = addr;
      ops.push_back(make_op(KIND_PLACED, addr, 8'h00));
    end else begin
      if (!started[fi]) begin
        started[fi] = 1'b1;
        wptr_tbl[fi] = start_tbl[fi];
        seg = seg_base(wptr_tbl[fi]);
        if (fi == 0 || seg != last_erased) begin
          last_erased = seg;
          ops.push_back(make_op(KIND_ERASE, seg, 8'h00));
        end
      end
      if (b.data_byte != BYTE_LF && b.data_byte != BYTE_CR) begin
        ops.push_back(make_op(KIND_PROGRAM, wptr_tbl[fi], b.data_byte));
        wptr_tbl[fi] = wptr_tbl[fi] + 16'd1;
      end
      if (b.chunk_end) ops.push_back(make_op(KIND_LOCK, 16'h0000, 8'h00));
    end
    if (ops.size() > 0) ops[ops.size() - 1].last = 1'b1;
    foreach (ops[k]) expected_ops.push_back(ops[k]);
  endtask

  task automatic queue_beat(input logic act, input int idx, input int len,
                            input logic [7:0] byte_val, input logic cend);
    file_beat_t b;
    b.action = act;
    b.file_index = 4'(idx);
    b.file_length = 13'(len);
    b.data_byte = byte_val;
    b.chunk_end = cend;
    pending_beats.push_back(b);
  endtask

  // Appends go to files 0..reach so that first appends spread over the phases.
  task automatic queue_random_items(input int count, input int reach, input bit allow_wrap);
    file_beat_t b;
    int         r;
    for (int n = 0; n < count; n++) begin
      b.action = ($urandom_range(0, 99) < 20) ? ACT_PLACE : ACT_APPEND;
      if (b.action == ACT_PLACE) begin
        b.file_index = 4'($urandom_range(0, FILE_COUNT - 1));
      end else begin
        b.file_index = 4'($urandom_range(0, reach));
        if (!allow_wrap && b.file_index == WRAP_FILE) b.file_index = 4'd0;
      end
      if ($urandom_range(0, 99) < 6) b.file_index = 4'($urandom_range(FILE_COUNT, 15));
      if ($urandom_range(0, 9) == 0) b.file_length = 13'($urandom);
      else b.file_length = 13'($urandom_range(0, 600));
      r = $urandom_range(0, 99);
      if (r < 8) b.data_byte = BYTE_LF;
      else if (r < 16) b.data_byte = BYTE_CR;
      else b.data_byte = 8'($urandom);
      b.chunk_end = ($urandom_range(0, 3) == 0);
      pending_beats.push_back(b);
    end
  endtask

  task automatic write_region_base(input logic [15:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued item went in and every expected result came out,
  // then give a dropped-byte item time to finish inside the block.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_ops.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Input driver.
  always @(negedge clk) begin : driver
    file_beat_t nxt;
    if (!rst && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        nxt = pending_beats.pop_front();
        action <= nxt.action;
        file_index <= nxt.file_index;
        file_length <= nxt.file_length;
        data_byte <= nxt.data_byte;
        chunk_end <= nxt.chunk_end;
        in_valid <= 1'b1;
        beats_sent++;
        gap_left = (beats_sent % 80 < 20) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, calm stretches, and one long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      ready_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && beats_in >= 150) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (ready_cycle % 256 < 48) begin
        out_ready <= 1'b1;
      end else begin
        hold_left = pick_gap();
        out_ready <= (hold_left == 0);
      end
    end
  end

  always @(posedge clk) begin : monitor
    file_beat_t cur;
    flash_op_t  want;
    if (!rst) begin
      in_taken = in_valid && in_ready;
      if (cfg_valid && cfg_ready) region_base = cfg_data;
      if (in_taken) begin
        cur.action = action;
        cur.file_index = file_index;
        cur.file_length = file_length;
        cur.data_byte = data_byte;
        cur.chunk_end = chunk_end;
        predict_flash_ops(cur);
        beats_in++;
      end
      if (out_valid && out_ready) begin
        if (expected_ops.size() == 0) begin
          if (errors < 50)
            $display("%0t: unexpected result beat kind=%0d address=%h data=%h last=%b",
                     $time, kind, address, data, last);
          errors++;
        end else begin
          want = expected_ops.pop_front();
          if (kind !== want.kind || address !== want.address ||
              data !== want.data || last !== want.last) begin
            if (errors < 50)
              $display("%0t: expected kind=%0d address=%h data=%h last=%b, %s%0d %s%h %s%h %s%b",
                       $time, want.kind, want.address, want.data, want.last,
                       "got kind=", kind, "address=", address, "data=", data,
                       "last=", last);
            errors++;
          end
        end
      end
    end
  end

  // A long run of cycles with no beat on any channel means the block hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("flash_file_place_and_append_core_test: done, errors");
      $finish;
    end
  end

  initial begin : sequencer
    logic [15:0] low_sum;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, run with the reset value of the region base.
    queue_beat(ACT_PLACE, 0, 0, 8'h00, 1'b0);
    queue_beat(ACT_PLACE, 1, 100, 8'h00, 1'b0);
    queue_beat(ACT_PLACE, 2, 512, 8'h00, 1'b0);   // crosses into the next segment
    queue_beat(ACT_PLACE, 3, 8191, 8'hFF, 1'b1);
    queue_beat(ACT_PLACE, 9, 4096, 8'h00, 1'b0);
    queue_beat(ACT_PLACE, 15, 1234, 8'h00, 1'b0); // bad index on place
    queue_beat(ACT_APPEND, 10, 0, 8'h41, 1'b1);   // bad index on append
    queue_beat(ACT_APPEND, 0, 0, 8'h00, 1'b0);    // first byte of file 0: erase
    queue_beat(ACT_APPEND, 0, 0, 8'hFF, 1'b1);
    queue_beat(ACT_APPEND, 0, 0, BYTE_LF, 1'b0);  // nothing comes out
    queue_beat(ACT_APPEND, 0, 0, BYTE_CR, 1'b1);  // lock only
    queue_beat(ACT_APPEND, 1, 0, 8'h41, 1'b0);    // same segment as last erase
    queue_beat(ACT_APPEND, 2, 0, BYTE_LF, 1'b1);  // erase and lock, no program
    queue_beat(ACT_APPEND, 2, 0, 8'h55, 1'b0);
    queue_beat(ACT_PLACE, 2, 1, 8'h00, 1'b0);     // re-place keeps the pointer
    queue_beat(ACT_APPEND, 2, 0, 8'h66, 1'b0);
    queue_beat(ACT_APPEND, 9, 0, 8'h80, 1'b1);    // erase, program and lock
    queue_beat(ACT_APPEND, 4, 0, 8'h7F, 1'b0);    // never placed: starts at zero
    queue_beat(ACT_PLACE, 4, 300, 8'h00, 1'b0);
    queue_beat(ACT_APPEND, 4, 0, 8'h01, 1'b1);
    queue_beat(ACT_PLACE, 0, 600, 8'h00, 1'b0);
    queue_beat(ACT_PLACE, 5, 0, 8'h00, 1'b0);
    wait_drained();

    write_region_base(16'h0000);
    queue_random_items(RANDOM_PER_PHASE, 3, 1'b0);
    wait_drained();

    write_region_base(16'hFFFF);
    queue_random_items(RANDOM_PER_PHASE, 5, 1'b0);
    wait_drained();

    write_region_base(16'($urandom));
    queue_random_items(RANDOM_PER_PHASE, 7, 1'b0);
    wait_drained();

    // Choose the base so that the reserved file starts two bytes below the top
    // of the address space, then walk its pointer across the wrap.
    low_sum = 16'h0000;
    for (int i = 0; i < WRAP_FILE; i++) low_sum = low_sum + 16'(length_tbl[i]);
    write_region_base(16'hFFFE - low_sum);
    queue_beat(ACT_PLACE, WRAP_FILE, 1, 8'h00, 1'b0);
    queue_beat(ACT_APPEND, WRAP_FILE, 0, 8'h31, 1'b0);
    queue_beat(ACT_APPEND, WRAP_FILE, 0, 8'h32, 1'b0);
    queue_beat(ACT_APPEND, WRAP_FILE, 0, 8'h33, 1'b1);
    queue_random_items(RANDOM_PER_PHASE, FILE_COUNT - 1, 1'b1);
    wait_drained();

    if (expected_ops.size() != 0)
      $display("%0t: %0d expected result beats never arrived", $time, expected_ops.size());
    if (errors == 0 && expected_ops.size() == 0) begin
      $display("flash_file_place_and_append_core_test: done, clean");
    end else begin
      $display("flash_file_place_and_append_core_test: done, errors");
    end
    $finish;
  end

endmodule
